// File: sv/clt_pkg.sv
package clt_pkg;

  localparam int unsigned HOLD_DEPTH_DEF = 16;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] LS_OK       = 2'd0;
  localparam logic [1:0] LS_UNTERM   = 2'd1;
  localparam logic [1:0] LS_EXTRA    = 2'd2;
  localparam logic [1:0] LS_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [8:0] {
    ST_PRE_KEY   = 9'b000000001,
    ST_KEY       = 9'b000000010,
    ST_AFTER_KEY = 9'b000000100,
    ST_UNQUOTED  = 9'b000001000,
    ST_QUOTED    = 9'b000010000,
    ST_AFTER_VAL = 9'b000100000,
    ST_ERROR     = 9'b001000000,
    ST_COMMENT   = 9'b010000000,
    ST_FLUSH     = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    SEL_RAW    = 3'd0,
    SEL_ESC    = 3'd1,
    SEL_STATUS = 3'd2,
    SEL_HELD   = 3'd3,
    SEL_PEND   = 3'd4
  } emit_sel_t;

  typedef struct packed {
    logic      emit;
    emit_sel_t sel;
    logic [1:0] kind;
    logic [1:0] status;
    logic      last;
    logic      push_hold;
    logic      set_ovf;
    logic      vb_set;
    logic      vb_clr;
    logic      set_quote;
    logic      load_pend;
    logic      flush_step;
    logic      line_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic is_ws;
    logic is_trim;
    logic is_hash;
    logic is_quote;
    logic is_bslash;
    logic is_close;
    logic esc_keep;
    logic value_begun;
    logic held_any;
    logic hold_full;
    logic flush_done;
    logic overflow;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_trim(input logic [7:0] c);
    return is_ws(c) || (c == CH_BS);
  endfunction

  // {keep, decoded byte}
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_SQ, CH_DQ, CH_BSL: r = {1'b1, c};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h76:   r = {1'b1, 8'h0B};
      8'h66:   r = {1'b1, 8'h0C};
      8'h62:   r = {1'b1, 8'h08};
      default: r = {1'b0, CH_NUL};
    endcase
    return r;
  endfunction

endpackage

// File: sv/clt_in_if.sv
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

// File: sv/clt_out_if.sv
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_char;
  logic [1:0] line_status;
  logic       last;

  modport source (output valid, output item_kind, output out_char, output line_status,
                  output last, input ready);
  modport sink   (input valid, input item_kind, input out_char, input line_status,
                  input last, output ready);
endinterface

// File: sv/clt_datapath.sv
module clt_datapath #(
  parameter int unsigned HOLD_DEPTH = clt_pkg::HOLD_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_char,
  input  clt_pkg::dp_cmd_t  cmd,
  output clt_pkg::dp_stat_t stat,
  clt_out_if.source         out_word
);

  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  logic [7:0]    hold_mem [HOLD_DEPTH];
  logic [CW-1:0] held_count_r, held_count_nxt;
  logic [CW-1:0] flush_idx_r, flush_idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          vb_r, vb_nxt;
  logic          quote_sq_r, quote_sq_nxt;
  logic [7:0]    pend_r;
  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic [7:0]    char_r;
  logic [1:0]    status_r;
  logic          last_r;
  logic [8:0]    esc;
  logic [7:0]    held_rd_r;
  logic [7:0]    emit_char;

  assign esc = clt_pkg::esc_decode(in_char);

  always_comb begin
    stat.is_ws       = clt_pkg::is_ws(in_char);
    stat.is_trim     = clt_pkg::is_trim(in_char);
    stat.is_hash     = (in_char == clt_pkg::CH_HASH);
    stat.is_quote    = (in_char == clt_pkg::CH_DQ) || (in_char == clt_pkg::CH_SQ);
    stat.is_bslash   = (in_char == clt_pkg::CH_BSL);
    stat.is_close    = (in_char == (quote_sq_r ? clt_pkg::CH_SQ : clt_pkg::CH_DQ));
    stat.esc_keep    = esc[8];
    stat.value_begun = vb_r;
    stat.held_any    = (held_count_r != '0);
    stat.hold_full   = (held_count_r == CW'(HOLD_DEPTH));
    stat.flush_done  = (flush_idx_r == held_count_r);
    stat.overflow    = ovf_r;
    stat.out_free    = !out_valid_r || out_word.ready;
  end

  always_comb begin
    held_count_nxt = held_count_r;
    flush_idx_nxt  = flush_idx_r;
    ovf_nxt        = ovf_r;
    vb_nxt         = vb_r;
    quote_sq_nxt   = quote_sq_r;
    if (cmd.push_hold) begin
      held_count_nxt = held_count_r + CW'(1);
    end
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.vb_clr) begin
      vb_nxt = 1'b0;
    end
    if (cmd.vb_set) begin
      vb_nxt = 1'b1;
    end
    if (cmd.set_quote) begin
      quote_sq_nxt = (in_char == clt_pkg::CH_SQ);
    end
    if (cmd.flush_step) begin
      if (stat.flush_done) begin
        flush_idx_nxt  = '0;
        held_count_nxt = '0;
      end else begin
        flush_idx_nxt = flush_idx_r + CW'(1);
      end
    end
    if (cmd.line_clear) begin
      held_count_nxt = '0;
      flush_idx_nxt  = '0;
      ovf_nxt        = 1'b0;
      vb_nxt         = 1'b0;
      quote_sq_nxt   = 1'b0;
    end
  end

  always_comb begin
    case (cmd.sel)
      clt_pkg::SEL_RAW:    emit_char = in_char;
      clt_pkg::SEL_ESC:    emit_char = esc[7:0];
      clt_pkg::SEL_HELD:   emit_char = held_rd_r;
      clt_pkg::SEL_PEND:   emit_char = pend_r;
      default:             emit_char = clt_pkg::CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
      flush_idx_r  <= '0;
      ovf_r        <= 1'b0;
      vb_r         <= 1'b0;
      quote_sq_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_count_r <= held_count_nxt;
      flush_idx_r  <= flush_idx_nxt;
      ovf_r        <= ovf_nxt;
      vb_r         <= vb_nxt;
      quote_sq_r   <= quote_sq_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // read ahead: entry for next cycle's flush index
  always_ff @(posedge clk) begin
    if (cmd.push_hold) begin
      hold_mem[held_count_r[IW-1:0]] <= in_char;
    end
    held_rd_r <= hold_mem[flush_idx_nxt[IW-1:0]];
    if (cmd.load_pend) begin
      pend_r <= in_char;
    end
    if (cmd.emit) begin
      kind_r   <= cmd.kind;
      char_r   <= emit_char;
      status_r <= cmd.status;
      last_r   <= cmd.last;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.item_kind   = kind_r;
  assign out_word.out_char    = char_r;
  assign out_word.line_status = status_r;
  assign out_word.last        = last_r;

endmodule

// File: sv/clt_ctrl.sv
module clt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  clt_pkg::dp_stat_t stat,
  output clt_pkg::dp_cmd_t  cmd,
  clt_in_if.sink            in_word
);

  clt_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_word.ready = (state_r != clt_pkg::ST_FLUSH) && stat.out_free;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sel        = clt_pkg::SEL_RAW;
    cmd.kind       = clt_pkg::KIND_VALUE;
    cmd.status     = clt_pkg::LS_OK;
    cmd.last       = 1'b1;

    if (state_r == clt_pkg::ST_FLUSH) begin
      if (stat.out_free) begin
        cmd.emit       = 1'b1;
        cmd.flush_step = 1'b1;
        if (stat.flush_done) begin
          cmd.sel    = clt_pkg::SEL_PEND;
          cmd.vb_set = 1'b1;
          state_nxt  = clt_pkg::ST_UNQUOTED;
        end else begin
          cmd.sel  = clt_pkg::SEL_HELD;
          cmd.last = 1'b0;
        end
      end
    end else if (accept && (in_word.opcode == clt_pkg::OP_EOL)) begin
      cmd.emit       = 1'b1;
      cmd.sel        = clt_pkg::SEL_STATUS;
      cmd.kind       = clt_pkg::KIND_STATUS;
      cmd.line_clear = 1'b1;
      if (state_r == clt_pkg::ST_QUOTED) begin
        cmd.status = clt_pkg::LS_UNTERM;
      end else if (state_r == clt_pkg::ST_ERROR) begin
        cmd.status = clt_pkg::LS_EXTRA;
      end else if (stat.overflow) begin
        cmd.status = clt_pkg::LS_OVERFLOW;
      end
      state_nxt = clt_pkg::ST_PRE_KEY;
    end else if (accept) begin
      case (state_r)
        clt_pkg::ST_PRE_KEY: begin
          if (!stat.is_ws) begin
            if (stat.is_hash) begin
              state_nxt = clt_pkg::ST_COMMENT;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = clt_pkg::KIND_KEY;
              state_nxt = clt_pkg::ST_KEY;
            end
          end
        end
        clt_pkg::ST_KEY: begin
          if (stat.is_ws) begin
            state_nxt = clt_pkg::ST_AFTER_KEY;
          end else if (stat.is_hash) begin
            state_nxt = clt_pkg::ST_COMMENT;
          end else begin
            cmd.emit = 1'b1;
            cmd.kind = clt_pkg::KIND_KEY;
          end
        end
        clt_pkg::ST_AFTER_KEY: begin
          if (!stat.is_ws) begin
            if (stat.is_quote) begin
              cmd.set_quote = 1'b1;
              cmd.vb_clr    = 1'b1;
              state_nxt     = clt_pkg::ST_QUOTED;
            end else if (stat.is_hash) begin
              state_nxt = clt_pkg::ST_COMMENT;
            end else begin
              cmd.vb_clr = 1'b1;
              state_nxt  = clt_pkg::ST_UNQUOTED;
              if (!stat.is_trim) begin
                cmd.emit   = 1'b1;
                cmd.vb_set = 1'b1;
              end
            end
          end
        end
        clt_pkg::ST_UNQUOTED: begin
          if (stat.is_hash) begin
            state_nxt = clt_pkg::ST_COMMENT;
          end else if (stat.is_trim) begin
            if (stat.value_begun) begin
              if (stat.hold_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.push_hold = 1'b1;
              end
            end
          end else if (stat.held_any) begin
            cmd.load_pend = 1'b1;
            state_nxt     = clt_pkg::ST_FLUSH;
          end else begin
            cmd.emit   = 1'b1;
            cmd.vb_set = 1'b1;
          end
        end
        clt_pkg::ST_QUOTED: begin
          if (stat.value_begun) begin
            cmd.vb_clr = 1'b1;
            if (stat.esc_keep) begin
              cmd.emit = 1'b1;
              cmd.sel  = clt_pkg::SEL_ESC;
            end
          end else if (stat.is_bslash) begin
            cmd.vb_set = 1'b1;
          end else if (stat.is_close) begin
            state_nxt = clt_pkg::ST_AFTER_VAL;
          end else begin
            cmd.emit = 1'b1;
          end
        end
        clt_pkg::ST_AFTER_VAL: begin
          if (!stat.is_ws) begin
            state_nxt = stat.is_hash ? clt_pkg::ST_COMMENT : clt_pkg::ST_ERROR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::ST_PRE_KEY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/config_line_tokenizer_core.sv
// A directly emitted result word is registered at the edge taking its input word.
// Throughput: one input word per cycle while output is drained and no flush runs;
//   a non-trim byte releasing held trim bytes follows them out while input stalls.
// The single output register sets the pace: input stalls while it is full and held.
// Reset: synchronous active-low rst_n returns the parser to before-key, clears flags,
//   hold count and output valid; hold buffer contents are not cleared.
module config_line_tokenizer_core #(
  parameter int unsigned HOLD_DEPTH = clt_pkg::HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  clt_in_if.sink    in_word,
  clt_out_if.source out_word
);

  clt_pkg::dp_cmd_t  cmd;
  clt_pkg::dp_stat_t stat;

  clt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .cmd     (cmd),
    .in_word (in_word)
  );

  clt_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_char  (in_word.char_code),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
